[hw/rtl/pmm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmm_pkg: shared types and constants for the modular polynomial multiplier
// Holds the sequencer state type, input word kinds, register indexes and the
// shared modular add/subtract function.
// ----------------------------------------------------------------------------
package pmm_pkg;

    localparam int DATA_W         = 64;
    localparam int BIT_W          = 6;
    localparam int MAX_DEGREE_DEF = 32;

    // Input word kinds.
    localparam logic [1:0] KIND_MUL  = 2'd0;
    localparam logic [1:0] KIND_DIV  = 2'd1;
    localparam logic [1:0] KIND_OPND = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_DEGREE  = 2'd1;
    localparam logic [1:0] REG_LINV    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED,
        S_PSTART,
        S_FETCH,
        S_LOAD,
        S_MDBL,
        S_MADD,
        S_MDONE,
        S_ACC,
        S_ORD,
        S_OLD,
        S_OWAIT
    } state_t;

    typedef enum logic [1:0] {
        PH_CONV,
        PH_QUOT,
        PH_SUB
    } phase_t;

    // Modular add (x + y + cin) or subtract (x - y); operands below m.
    function automatic logic [DATA_W-1:0] pmm_addsub(
        input logic [DATA_W-1:0] x,
        input logic [DATA_W-1:0] y,
        input logic              cin,
        input logic [DATA_W-1:0] m,
        input logic              sub
    );
        logic [DATA_W:0] s;
        logic [DATA_W:0] t;
        logic [DATA_W:0] mx;
        mx = {1'b0, m};
        if (sub)
        begin
            t = {1'b0, x} - {1'b0, y};
            s = t[DATA_W] ? {1'b0, t[DATA_W-1:0] + m} : t;
            return s[DATA_W-1:0];
        end
        else
        begin
            s = {1'b0, x} + {1'b0, y} + {{DATA_W{1'b0}}, cin};
            t = s - mx;
            return (s >= mx) ? t[DATA_W-1:0] : s[DATA_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

[hw/rtl/poly_mulmod_fixed_multiplier_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// poly_mulmod_fixed_multiplier_unit: a * b mod d over integers mod m
// Loads multiplier and divisor coefficients, then multiplies each operand
// polynomial by the multiplier and reduces it by long division with d.
// ----------------------------------------------------------------------------
// Usage: write modulus, degree and lead_inverse on the cfg port while idle.
// Input words (valid/stall) load multiplier (kind 0), divisor (kind 1) or
// operand (kind 2) coefficients. A stored value is reduced mod m by a 64-step
// shift-subtract loop; a modulus below two stores zero at once. An operand
// word with last set starts the product: lead_inverse is reduced, then n*n
// multiply-accumulates, n-1 quotient multiplies and (n-1)*(n+1) subtract
// multiplies each run through one shared 65-bit modular adder.
// The n result words leave lowest first; the output register holds a word
// for as long as out_stall is high. in_stall is high whenever a word is in
// progress. Reset clears all stored coefficients to zero and sets modulus 2,
// degree 1, lead_inverse 1. The operand store is cleared once the last
// result word is taken.
// ----------------------------------------------------------------------------
module poly_mulmod_fixed_multiplier_unit
    import pmm_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [DATA_W-1:0] cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        kind,
    input  wire logic [5:0]        index,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic              last,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [DATA_W-1:0]      coeff_out,
    output logic [4:0]             coeff_index,
    output logic                   final_res
);

    localparam int AW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int CW = $clog2(MAX_DEGREE + 1);
    localparam int PW = $clog2(2 * MAX_DEGREE);
    localparam int PD = 2 * MAX_DEGREE;

    // Configuration registers.
    logic [DATA_W-1:0] mod_reg;
    logic [5:0]        deg_reg;
    logic [DATA_W-1:0] linv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg  <= DATA_W'(2);
            deg_reg  <= 6'd1;
            linv_reg <= DATA_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODULUS: mod_reg  <= cfg_wr_data;
                REG_DEGREE:  deg_reg  <= cfg_wr_data[5:0];
                REG_LINV:    linv_reg <= cfg_wr_data;
                default:     ;
            endcase
        end
    end

    // Effective degree, clamped to 1..MAX_DEGREE.
    logic [CW-1:0] n_w;
    logic          mod_ok;
    assign n_w = (deg_reg == 6'd0) ? CW'(1) :
                 ({2'b0, deg_reg} > 8'(MAX_DEGREE)) ? CW'(MAX_DEGREE) : CW'(deg_reg);
    assign mod_ok = |mod_reg[DATA_W-1:1];

    // Sequencer registers.
    state_t            state_reg, state_next;
    phase_t            ph_reg, ph_next;
    logic [1:0]        kind_reg, kind_next;
    logic [5:0]        idx_reg, idx_next;
    logic              last_reg, last_next;
    logic              red_li_reg, red_li_next;
    logic [DATA_W-1:0] src_reg, src_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] opx_reg, opx_next;
    logic [DATA_W-1:0] opy_reg, opy_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] li_reg, li_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [PW-1:0]     k_reg, k_next;
    logic [PW-1:0]     pidx_reg, pidx_next;
    logic              ov_reg, ov_next;
    logic [DATA_W-1:0] oc_reg, oc_next;
    logic [4:0]        oi_reg, oi_next;
    logic              of_reg, of_next;

    // Shared modular add/subtract unit.
    logic [DATA_W-1:0] u_x, u_y, u_res;
    logic              u_cin, u_sub;
    assign u_res = pmm_addsub(u_x, u_y, u_cin, mod_reg, u_sub);

    // Memory controls.
    logic              a_we, d_we, b_we, p_we, p_clr, b_clr;
    logic [5:0]        wr_idx;
    logic [DATA_W-1:0] wr_data;
    logic [PW-1:0]     p_raddr;
    logic [DATA_W-1:0] a_rd, b_rd, d_rd, p_rd;

    // Multiplier coefficient store.
    logic [DATA_W-1:0] a_mem [MAX_DEGREE];
    logic [MAX_DEGREE-1:0] a_vld;
    logic [DATA_W-1:0] a_mq;
    logic              a_vq;

    always_ff @(posedge clk)
    begin
        if (a_we)
            a_mem[AW'(wr_idx)] <= wr_data;
        a_mq <= a_mem[i_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld <= '0;
            a_vq  <= 1'b0;
        end
        else
        begin
            if (a_we)
                a_vld[AW'(wr_idx)] <= 1'b1;
            a_vq <= a_vld[i_reg[AW-1:0]];
        end
    end
    assign a_rd = a_vq ? a_mq : '0;

    // Operand coefficient store, cleared after each product.
    logic [DATA_W-1:0] b_mem [MAX_DEGREE];
    logic [MAX_DEGREE-1:0] b_vld;
    logic [DATA_W-1:0] b_mq;
    logic              b_vq;

    always_ff @(posedge clk)
    begin
        if (b_we)
            b_mem[AW'(wr_idx)] <= wr_data;
        b_mq <= b_mem[j_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld <= '0;
            b_vq  <= 1'b0;
        end
        else
        begin
            if (b_clr)
                b_vld <= '0;
            if (b_we)
                b_vld[AW'(wr_idx)] <= 1'b1;
            b_vq <= b_vld[j_reg[AW-1:0]];
        end
    end
    assign b_rd = b_vq ? b_mq : '0;

    // Divisor coefficient store.
    logic [DATA_W-1:0] d_mem [MAX_DEGREE+1];
    logic [MAX_DEGREE:0] d_vld;
    logic [DATA_W-1:0] d_mq;
    logic              d_vq;

    always_ff @(posedge clk)
    begin
        if (d_we)
            d_mem[CW'(wr_idx)] <= wr_data;
        d_mq <= d_mem[i_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld <= '0;
            d_vq  <= 1'b0;
        end
        else
        begin
            if (d_we)
                d_vld[CW'(wr_idx)] <= 1'b1;
            d_vq <= d_vld[i_reg];
        end
    end
    assign d_rd = d_vq ? d_mq : '0;

    // Product memory, cleared at the start of each product.
    logic [DATA_W-1:0] p_mem [PD];
    logic [PD-1:0]     p_vld;
    logic [DATA_W-1:0] p_mq;
    logic              p_vq;

    always_ff @(posedge clk)
    begin
        if (p_we)
            p_mem[pidx_reg] <= u_res;
        p_mq <= p_mem[p_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld <= '0;
            p_vq  <= 1'b0;
        end
        else
        begin
            if (p_clr)
                p_vld <= '0;
            if (p_we)
                p_vld[pidx_reg] <= 1'b1;
            p_vq <= p_vld[p_raddr];
        end
    end
    assign p_rd = p_vq ? p_mq : '0;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ph_reg     <= PH_CONV;
            red_li_reg <= 1'b0;
            ov_reg     <= 1'b0;
            bit_reg    <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            pidx_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ph_reg     <= ph_next;
            red_li_reg <= red_li_next;
            ov_reg     <= ov_next;
            bit_reg    <= bit_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            pidx_reg   <= pidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
        src_reg  <= src_next;
        acc_reg  <= acc_next;
        opx_reg  <= opx_next;
        opy_reg  <= opy_next;
        q_reg    <= q_next;
        li_reg   <= li_next;
        oc_reg   <= oc_next;
        oi_reg   <= oi_next;
        of_reg   <= of_next;
    end

    // Next state and datapath control.
    logic [7:0] idx8;
    logic       store_need;
    logic       prod_go;
    assign idx8 = {2'b0, index};

    always_comb
    begin
        case (kind)
            KIND_MUL:  store_need = idx8 < 8'(MAX_DEGREE);
            KIND_DIV:  store_need = idx8 <= 8'(MAX_DEGREE);
            KIND_OPND: store_need = idx8 < 8'(n_w);
            default:   store_need = 1'b0;
        endcase
        prod_go = (kind == KIND_OPND) && last;
    end

    always_comb
    begin
        state_next  = state_reg;
        ph_next     = ph_reg;
        kind_next   = kind_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        red_li_next = red_li_reg;
        src_next    = src_reg;
        acc_next    = acc_reg;
        opx_next    = opx_reg;
        opy_next    = opy_reg;
        q_next      = q_reg;
        li_next     = li_reg;
        bit_next    = bit_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        pidx_next   = pidx_reg;
        ov_next     = ov_reg;
        oc_next     = oc_reg;
        oi_next     = oi_reg;
        of_next     = of_reg;
        u_x         = acc_reg;
        u_y         = acc_reg;
        u_cin       = 1'b0;
        u_sub       = 1'b0;
        a_we        = 1'b0;
        d_we        = 1'b0;
        b_we        = 1'b0;
        p_we        = 1'b0;
        p_clr       = 1'b0;
        b_clr       = 1'b0;
        wr_idx      = (state_reg == S_IDLE) ? index : idx_reg;
        wr_data     = (state_reg == S_IDLE) ? '0 : u_res;
        p_raddr     = pidx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = kind;
                    idx_next    = index;
                    last_next   = last;
                    src_next    = value;
                    acc_next    = '0;
                    bit_next    = BIT_W'(DATA_W - 1);
                    red_li_next = 1'b0;
                    state_next  = prod_go ? S_PSTART : S_IDLE;
                    if (store_need)
                    begin
                        if (mod_ok)
                            state_next = S_RED;
                        else
                        begin
                            // Modulus below two stores zero at once.
                            a_we = (kind == KIND_MUL);
                            d_we = (kind == KIND_DIV);
                            b_we = (kind == KIND_OPND);
                        end
                    end
                end
            end

            // One shift-subtract step of value mod m per cycle.
            S_RED:
            begin
                u_cin    = src_reg[bit_reg];
                acc_next = u_res;
                if (bit_reg == '0)
                begin
                    if (red_li_reg)
                    begin
                        li_next    = u_res;
                        i_next     = '0;
                        j_next     = '0;
                        ph_next    = PH_CONV;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        a_we = (kind_reg == KIND_MUL);
                        d_we = (kind_reg == KIND_DIV);
                        b_we = (kind_reg == KIND_OPND);
                        state_next = (last_reg && kind_reg == KIND_OPND) ? S_PSTART : S_IDLE;
                    end
                end
                else
                    bit_next = bit_reg - 1'b1;
            end

            S_PSTART:
            begin
                p_clr  = 1'b1;
                i_next = '0;
                if (mod_ok)
                begin
                    red_li_next = 1'b1;
                    src_next    = linv_reg;
                    acc_next    = '0;
                    bit_next    = BIT_W'(DATA_W - 1);
                    state_next  = S_RED;
                end
                else
                    state_next = S_ORD;
            end

            S_FETCH:
            begin
                if (ph_reg == PH_QUOT)
                    p_raddr = k_reg;
                state_next = S_LOAD;
            end

            // Operands are back from the stores: set up one multiply.
            S_LOAD:
            begin
                acc_next = '0;
                bit_next = BIT_W'(DATA_W - 1);
                case (ph_reg)
                    PH_CONV:
                    begin
                        opx_next  = a_rd;
                        opy_next  = b_rd;
                        pidx_next = PW'(i_reg) + PW'(j_reg);
                    end
                    PH_QUOT:
                    begin
                        opx_next = p_rd;
                        opy_next = li_reg;
                    end
                    PH_SUB:
                    begin
                        opx_next  = q_reg;
                        opy_next  = d_rd;
                        pidx_next = k_reg - PW'(n_w) + PW'(i_reg);
                    end
                    default: ;
                endcase
                state_next = S_MDBL;
            end

            // Double-and-add multiply, most significant bit first.
            S_MDBL:
            begin
                acc_next = u_res;
                if (opy_reg[bit_reg])
                    state_next = S_MADD;
                else if (bit_reg == '0)
                    state_next = S_MDONE;
                else
                    bit_next = bit_reg - 1'b1;
            end

            S_MADD:
            begin
                u_y      = opx_reg;
                acc_next = u_res;
                if (bit_reg == '0)
                    state_next = S_MDONE;
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = S_MDBL;
                end
            end

            S_MDONE:
            begin
                if (ph_reg == PH_QUOT)
                begin
                    q_next     = acc_reg;
                    ph_next    = PH_SUB;
                    i_next     = '0;
                    state_next = S_FETCH;
                end
                else
                    state_next = S_ACC;
            end

            // Accumulate into or subtract from the product word.
            S_ACC:
            begin
                u_x  = p_rd;
                u_y  = acc_reg;
                p_we = 1'b1;
                if (ph_reg == PH_SUB)
                begin
                    u_sub = 1'b1;
                    if (i_reg == n_w)
                    begin
                        if (k_reg == PW'(n_w))
                        begin
                            i_next     = '0;
                            state_next = S_ORD;
                        end
                        else
                        begin
                            k_next     = k_reg - 1'b1;
                            ph_next    = PH_QUOT;
                            state_next = S_FETCH;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_FETCH;
                    end
                end
                else
                begin
                    state_next = S_FETCH;
                    if (j_reg == n_w - 1'b1)
                    begin
                        j_next = '0;
                        if (i_reg == n_w - 1'b1)
                        begin
                            i_next = '0;
                            if (n_w == CW'(1))
                                state_next = S_ORD;
                            else
                            begin
                                k_next  = PW'(n_w) + PW'(n_w) - PW'(2);
                                ph_next = PH_QUOT;
                            end
                        end
                        else
                            i_next = i_reg + 1'b1;
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
            end

            S_ORD:
            begin
                p_raddr    = PW'(i_reg);
                state_next = S_OLD;
            end

            S_OLD:
            begin
                ov_next    = 1'b1;
                oc_next    = p_rd;
                oi_next    = 5'(i_reg);
                of_next    = (i_reg == n_w - 1'b1);
                state_next = S_OWAIT;
            end

            S_OWAIT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    if (of_reg)
                    begin
                        b_clr      = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = ov_reg;
    assign coeff_out   = oc_reg;
    assign coeff_index = oi_reg;
    assign final_res   = of_reg;

    // A result word is only shown while the sequencer waits on it.
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> state_reg == S_OWAIT)
        else $error("result word outside output wait");

    // Every result word is reduced below the modulus.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mod_ok) |-> coeff_out < mod_reg)
        else $error("result word not reduced");

    // Taking the last word of a product returns the block to idle.
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && final_res) |=> state_reg == S_IDLE)
        else $error("block not idle after final word");

endmodule
`default_nettype wire

[bench/poly_mulmod_fixed_multiplier_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for poly_mulmod_fixed_multiplier_unit
// Loads multiplier and divisor coefficients under several modulus, degree and
// lead-inverse settings, streams operand polynomials through the block and
// checks every remainder word against a bit-exact long-division predictor.
// ----------------------------------------------------------------------------
module poly_mulmod_fixed_multiplier_unit_tb
    import pmm_pkg::*;
();

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int SETTLE = 200;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] coeff;
        logic [4:0]  pos;
        logic        fin;
    } rem_word_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [63:0]       cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        kind;
    logic [5:0]        index;
    logic [63:0]       value;
    logic              last;
    logic              out_valid;
    logic              out_stall;
    logic [63:0]       coeff_out;
    logic [4:0]        coeff_index;
    logic              final_res;

    // Predictor state.
    logic [63:0] mod_m;
    logic [5:0]  deg_r;
    logic [63:0] linv_r;
    logic [63:0] mul_store [32];
    logic [63:0] div_store [33];
    logic [63:0] opnd_store [32];
    rem_word_t   expected_rem [$];

    int  error_count;
    int  words_sent;
    int  cycle_count;
    bit  gaps_on;

    poly_mulmod_fixed_multiplier_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .index       (index),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .coeff_out   (coeff_out),
        .coeff_index (coeff_index),
        .final_res   (final_res)
    );

    always #5 clk = ~clk;

    // Modular helpers with the same wraparound behavior as the block.
    function automatic logic [63:0] mod_add(logic [63:0] x, logic [63:0] y);
        logic [63:0] gap;
        gap = mod_m - y;
        return (x >= gap) ? x - gap : x + y;
    endfunction

    function automatic logic [63:0] mod_sub(logic [63:0] x, logic [63:0] y);
        return (x >= y) ? x - y : x + (mod_m - y);
    endfunction

    function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y);
        logic [63:0] acc;
        acc = '0;
        for (int b = 63; b >= 0; b--)
        begin
            acc = mod_add(acc, acc);
            if (y[b])
                acc = mod_add(acc, x);
        end
        return acc;
    endfunction

    function automatic logic [63:0] reduce_val(logic [63:0] x);
        return (mod_m < 2) ? 64'd0 : x % mod_m;
    endfunction

    function automatic int eff_degree();
        if (deg_r == 0)
            return 1;
        if (deg_r > 32)
            return 32;
        return int'(deg_r);
    endfunction

    // Forms a*b, divides by d and queues the remainder words.
    function automatic void predict_remainder();
        logic [63:0] prod [64];
        logic [63:0] q;
        logic [63:0] li;
        int n;
        rem_word_t w;
        n = eff_degree();
        for (int i = 0; i < 64; i++)
            prod[i] = '0;
        if (mod_m >= 2)
        begin
            li = linv_r % mod_m;
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    prod[i+j] = mod_add(prod[i+j], mod_mul(mul_store[i], opnd_store[j]));
            for (int k = 2 * n - 2; k >= n; k--)
            begin
                q = mod_mul(prod[k], li);
                for (int i = 0; i <= n; i++)
                    prod[k-n+i] = mod_sub(prod[k-n+i], mod_mul(q, div_store[i]));
            end
        end
        for (int i = 0; i < n; i++)
        begin
            w.coeff = prod[i];
            w.pos = i[4:0];
            w.fin = (i + 1 == n);
            expected_rem.push_back(w);
        end
        for (int i = 0; i < 32; i++)
            opnd_store[i] = '0;
    endfunction

    // Applies one accepted input word to the predictor.
    function automatic void accept_word(logic [1:0] k, logic [5:0] idx, logic [63:0] v,
                                        logic l);
        case (k)
            KIND_MUL:
                if (idx < 32)
                    mul_store[idx] = reduce_val(v);
            KIND_DIV:
                if (idx <= 32)
                    div_store[idx] = reduce_val(v);
            KIND_OPND:
            begin
                if (idx < eff_degree())
                    opnd_store[idx] = reduce_val(v);
                if (l)
                    predict_remainder();
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Sends one word; called at a rising edge, returns at its acceptance edge.
    task automatic send_word(input logic [1:0] k, input logic [5:0] idx,
                             input logic [63:0] v, input logic l);
        while (gaps_on && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        index <= idx;
        value <= v;
        last <= l;
        do
            @(posedge clk);
        while (in_stall);
        accept_word(k, idx, v, l);
        words_sent++;
    endtask

    // Lowers valid and waits until every remainder word has come and the
    // block has had time to finish a coefficient load.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (expected_rem.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
        case (idx)
            REG_MODULUS: mod_m = data;
            REG_DEGREE:  deg_r = data[5:0];
            REG_LINV:    linv_r = data;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [63:0] m, input logic [63:0] d,
                              input logic [63:0] li);
        drain_block();
        write_reg(REG_MODULUS, m);
        write_reg(REG_DEGREE, d);
        write_reg(REG_LINV, li);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Sends one operand polynomial in shuffled order, last on the final word.
    task automatic send_operand(input int n, input bit zero_vec, input bit noisy);
        int order [$];
        for (int i = 0; i < n; i++)
            order.push_back(i);
        order.shuffle();
        foreach (order[i])
        begin
            if (noisy && $urandom_range(3) == 0)
                send_word(KIND_NONE, 6'($urandom_range(63)), rand64(),
                          1'($urandom_range(1)));
            send_word(KIND_OPND, 6'(order[i]), zero_vec ? 64'd0 : rand64() % mod_m,
                      i == n - 1);
        end
    endtask

    task automatic load_polys(input int n, input bit monic);
        for (int i = 0; i < n; i++)
            send_word(KIND_MUL, 6'(i), rand64(), 1'b0);
        for (int i = 0; i <= n; i++)
            send_word(KIND_DIV, 6'(i), (monic && i == n) ? 64'd1 : rand64(), 1'b0);
    endtask

    // Reset state: degree 1, modulus 2, all stores zero; ignored words.
    task automatic test_reset_state();
        send_word(KIND_OPND, 6'd0, 64'd1, 1'b1);
        send_word(KIND_NONE, 6'd63, ALL_ONES, 1'b1);
        send_word(KIND_MUL, 6'd0, 64'd3, 1'b1);
        send_word(KIND_DIV, 6'd1, 64'd1, 1'b1);
        send_word(KIND_OPND, 6'd0, 64'd1, 1'b1);
    endtask

    // Largest modulus, unreduced values, out-of-range indexes, wrong inverse.
    task automatic test_field_extremes();
        set_config(ALL_ONES, 64'd2, 64'd1);
        send_word(KIND_MUL, 6'd0, ALL_ONES, 1'b0);
        send_word(KIND_MUL, 6'd1, ALL_ONES - 1, 1'b0);
        send_word(KIND_MUL, 6'd63, 64'd5, 1'b0);
        send_word(KIND_MUL, 6'd32, 64'd5, 1'b0);
        send_word(KIND_DIV, 6'd0, ALL_ONES - 1, 1'b0);
        send_word(KIND_DIV, 6'd1, 64'd7, 1'b0);
        send_word(KIND_DIV, 6'd2, 64'd1, 1'b0);
        send_word(KIND_DIV, 6'd33, 64'd9, 1'b0);
        send_word(KIND_OPND, 6'd0, ALL_ONES - 1, 1'b0);
        send_word(KIND_OPND, 6'd1, ALL_ONES, 1'b0);
        send_word(KIND_OPND, 6'd40, 64'd3, 1'b1);
        set_config(ALL_ONES, 64'd2, 64'd0);
        send_word(KIND_OPND, 6'd1, 64'd12345, 1'b1);
        set_config(ALL_ONES, 64'd2, ALL_ONES);
        send_word(KIND_OPND, 6'd1, ALL_ONES - 1, 1'b1);
    endtask

    // Modulus below two and degree out of range at the low end.
    task automatic test_small_modulus();
        set_config(64'd0, 64'd0, 64'd1);
        send_word(KIND_MUL, 6'd0, 64'd9, 1'b0);
        send_word(KIND_OPND, 6'd0, 64'd9, 1'b1);
        set_config(64'd1, 64'd3, 64'd1);
        send_word(KIND_OPND, 6'd2, 64'd9, 1'b1);
    endtask

    // One product at the largest degree, set through an oversized value.
    task automatic test_full_degree();
        set_config(rand64() | 64'd2, 64'd45, 64'd1);
        load_polys(32, 1'b1);
        send_operand(32, 1'b0, 1'b0);
    endtask

    // Random settings, each followed by several operand polynomials.
    task automatic test_random_products(input int target);
        int n;
        bit monic;
        while (words_sent < target)
        begin
            gaps_on = (words_sent < target / 2) || (words_sent > 3 * target / 4);
            n = $urandom_range(1, 4);
            monic = $urandom_range(1);
            set_config(($urandom_range(3) == 0) ? 64'($urandom_range(2, 1000)) : rand64(),
                       64'(n), monic ? 64'd1 : rand64());
            load_polys(n, monic);
            repeat ($urandom_range(3, 6))
                send_operand(n, $urandom_range(9) == 0, $urandom_range(4) == 0);
        end
        gaps_on = 1'b1;
    endtask

    // Output stall and result checking.
    always @(posedge clk)
    begin
        rem_word_t w;
        if (out_valid && !out_stall)
        begin
            if (expected_rem.size() == 0)
                report_mismatch("result word with none expected");
            else
            begin
                w = expected_rem.pop_front();
                if (coeff_out !== w.coeff)
                    report_mismatch($sformatf("coeff_out %h, want %h", coeff_out, w.coeff));
                if (coeff_index !== w.pos)
                    report_mismatch($sformatf("coeff_index %0d, want %0d", coeff_index, w.pos));
                if (final_res !== w.fin)
                    report_mismatch($sformatf("final_res %b, want %b", final_res, w.fin));
            end
        end
        out_stall <= gaps_on && ($urandom_range(99) < 11);
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MODULUS;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        kind = KIND_MUL;
        index = '0;
        value = '0;
        last = 1'b0;
        out_stall = 1'b0;
        error_count = 0;
        words_sent = 0;
        cycle_count = 0;
        gaps_on = 1'b1;
        mod_m = 64'd2;
        deg_r = 6'd1;
        linv_r = 64'd1;
        for (int i = 0; i < 32; i++)
        begin
            mul_store[i] = '0;
            opnd_store[i] = '0;
        end
        for (int i = 0; i < 33; i++)
            div_store[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_field_extremes();
        test_small_modulus();
        test_full_degree();
        test_random_products(380);
        drain_block();

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
hw/rtl/pmm_pkg.sv
hw/rtl/poly_mulmod_fixed_multiplier_unit.sv
bench/poly_mulmod_fixed_multiplier_unit_tb.sv
